@@ sv/nnsf_pkg.sv @@
// shared constants and types for the nearest neighbor series forecast block
package nnsf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int USED_W   = 5;
  localparam int EMBED_W  = 4;
  localparam int NBR_W    = 5;
  localparam int START_W  = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_AW   = 2;

  localparam logic [CFG_AW-1:0] REG_EMBED_DIM      = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NEIGHBOR_COUNT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_START_POINT    = 2'd2;

  localparam logic [EMBED_W-1:0] EMBED_RESET = 4'd2;
  localparam logic [NBR_W-1:0]   NBR_RESET   = 5'd1;
  localparam logic [START_W-1:0] START_RESET = 11'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

@@ sv/nnsf_cell.sv @@
// one cell of the sorting chain: keeps the smaller candidate, passes the other on
module nnsf_cell #(
  parameter int DW = 36,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clr,
  input  logic          in_v,
  input  logic [DW-1:0] in_d,
  input  logic [IW-1:0] in_idx,
  output logic          out_v,
  output logic [DW-1:0] out_d,
  output logic [IW-1:0] out_idx,
  output logic          occ,
  output logic [IW-1:0] idx
);

  logic [DW-1:0] d;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      occ   <= 1'b0;
      out_v <= 1'b0;
    end else if (in_v) begin
      if (!occ) begin
        occ   <= 1'b1;
        out_v <= 1'b0;
      end else begin
        out_v <= 1'b1;
      end
    end else begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_v) begin
      if (!occ || in_d < d) begin
        d       <= in_d;
        idx     <= in_idx;
        out_d   <= d;
        out_idx <= idx;
      end else begin
        out_d   <= in_d;
        out_idx <= in_idx;
      end
    end
  end

endmodule

@@ sv/nnsf_div.sv @@
// signed by unsigned restoring divider, one quotient bit per cycle, truncates toward zero
module nnsf_div #(
  parameter int SW = 21,
  parameter int NW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [SW-1:0] dividend,
  input  logic [NW-1:0]        divisor,
  output logic                 done,
  output logic signed [SW-1:0] quotient
);

  localparam int CW = $clog2(SW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [SW-1:0] q;
  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic [NW:0]   rem_sh;
  logic          take;

  assign rem_sh   = {rem, q[SW-1]};
  assign take     = rem_sh >= {1'b0, dvs};
  assign quotient = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && cnt == CW'(1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SW-1];
      q   <= dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? NW'(rem_sh - {1'b0, dvs}) : rem_sh[NW-1:0];
      q   <= {q[SW-2:0], take};
    end
  end

endmodule

@@ sv/nearest_neighbor_series_forecast_top.sv @@
// top level of the nearest neighbor series forecast block
// Each input transfer stores one sample, unless the history is full, and
// returns one result. A rejected sample (history full) or one that gives no
// forecast skips the search and goes straight to the result. For a forecast,
// the single history memory read port fetches one sample per cycle, first
// the newest embedding vector and then each candidate vector; the sorting
// chain then settles, the neighbor successors are read one per cycle, and
// the divider gives one quotient bit per cycle. Results wait in an output
// register.
module nearest_neighbor_series_forecast_top #(
  parameter int HISTORY_DEPTH = 1024,
  parameter int MAX_EMBED     = 8,
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [15:0]                s_tdata,  // sample
  input  logic [0:0]                 s_tuser,  // clear
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,  // forecast_value, neighbors_used, zero fill
  output logic [1:0]                 m_tuser,  // forecast_valid, history_full
  input  logic                       cfg_we,
  input  logic [nnsf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [nnsf_pkg::CFG_W-1:0] cfg_data
);
  import nnsf_pkg::*;

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
  localparam int MW   = $clog2(MAX_EMBED + 1);
  localparam int TW   = MAX_EMBED > 1 ? $clog2(MAX_EMBED) : 1;
  localparam int KW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int CW   = MAX_NEIGHBORS > 1 ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int DW   = 2 * SAMPLE_W + MW;
  localparam int SW   = SAMPLE_W + KW + 1;
  localparam int DRW  = $clog2(MAX_NEIGHBORS + 5);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VEC   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_SUMW  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_VEC  = 2'd1;
  localparam logic [1:0] K_DIST = 2'd2;
  localparam logic [1:0] K_SUM  = 2'd3;

  logic [EMBED_W-1:0] embed_dim;
  logic [NBR_W-1:0]   neighbor_count;
  logic [START_W-1:0] start_point;

  logic [2:0]      state;
  logic [CNTW-1:0] count;
  logic [AW-1:0]   newest;
  logic [AW-1:0]   j;
  logic [MW-1:0]   t;
  logic [KW-1:0]   filled;
  logic [KW-1:0]   i;
  logic [DRW-1:0]  drain;
  logic signed [SW-1:0] sum;

  logic [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
  logic [SAMPLE_W-1:0] rdata;
  logic [AW-1:0]       rd_addr;
  logic [1:0]          rd_kind;
  sample_t             vec [MAX_EMBED];

  logic          p1_v, p1_first, p1_last;
  logic [1:0]    p1_kind;
  logic [TW-1:0] p1_t;
  logic [AW-1:0] p1_idx;
  logic          sq_v, sq_first, sq_last;
  logic [AW-1:0] sq_idx;
  logic [2*SAMPLE_W-1:0] sq;
  logic          acc_done;
  logic [AW-1:0] acc_idx;
  logic [DW-1:0] acc;
  logic [DW-1:0] acc_new;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0]      diff_mag;

  logic [MW-1:0]   m;
  logic [KW-1:0]   k;
  logic [START_W-1:0] sp;
  logic [CNTW-1:0] cnt_eff;
  logic [CNTW-1:0] n;
  logic [CNTW-1:0] newest_calc;
  logic            accept;
  logic            clr_chain;
  logic            last_issue;

  logic                div_start, div_done;
  logic signed [SW-1:0] quotient;

  sample_t         res_value;
  logic            res_valid, res_full;
  logic [USED_W-1:0] res_used;

  logic [MAX_NEIGHBORS:0]          ch_v;
  logic [DW-1:0]                   ch_d   [MAX_NEIGHBORS+1];
  logic [AW-1:0]                   ch_idx [MAX_NEIGHBORS+1];
  logic [MAX_NEIGHBORS-1:0]        c_occ;
  logic [AW-1:0]                   c_idx  [MAX_NEIGHBORS];

  assign m = embed_dim == '0 ? MW'(1) :
             (32'(embed_dim) > MAX_EMBED ? MW'(MAX_EMBED) : MW'(embed_dim));
  assign k = neighbor_count == '0 ? KW'(1) :
             (32'(neighbor_count) > MAX_NEIGHBORS ? KW'(MAX_NEIGHBORS) : KW'(neighbor_count));
  assign sp = start_point == '0 ? START_W'(1) : start_point;

  assign accept      = s_tvalid && s_tready;
  assign s_tready    = state == S_IDLE;
  assign cnt_eff     = s_tuser[0] ? '0 : count;
  assign n           = cnt_eff + 1'b1;
  assign newest_calc = n - CNTW'(m);
  assign last_issue  = j == AW'(newest - 1'b1) && t == m - 1'b1;
  assign clr_chain   = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      embed_dim      <= EMBED_RESET;
      neighbor_count <= NBR_RESET;
      start_point    <= START_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EMBED_DIM:      embed_dim      <= cfg_data[EMBED_W-1:0];
        REG_NEIGHBOR_COUNT: neighbor_count <= cfg_data[NBR_W-1:0];
        REG_START_POINT:    start_point    <= cfg_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_kind = K_NONE;
    rd_addr = '0;
    unique case (state)
      S_VEC: begin
        rd_kind = K_VEC;
        rd_addr = AW'(newest + AW'(t));
      end
      S_SCAN: begin
        rd_kind = K_DIST;
        rd_addr = AW'(j + AW'(t));
      end
      S_SUM: begin
        rd_kind = K_SUM;
        rd_addr = AW'(c_idx[i[CW-1:0]] + AW'(m));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cnt_eff != CNTW'(HISTORY_DEPTH)) begin
      mem[cnt_eff[AW-1:0]] <= s_tdata;
    end
    rdata <= mem[rd_addr];
  end

  assign diff     = $signed({rdata[SAMPLE_W-1], rdata}) - $signed({vec[p1_t][SAMPLE_W-1], vec[p1_t]});
  assign diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
  assign acc_new  = (sq_first ? '0 : acc) + DW'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v     <= 1'b0;
      sq_v     <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      p1_v     <= rd_kind != K_NONE;
      sq_v     <= p1_v && p1_kind == K_DIST;
      acc_done <= sq_v && sq_last;
    end
  end

  always_ff @(posedge clk) begin
    p1_kind  <= rd_kind;
    p1_t     <= t[TW-1:0];
    p1_first <= t == '0;
    p1_last  <= t == m - 1'b1;
    p1_idx   <= j;
    if (p1_v && p1_kind == K_VEC) begin
      vec[p1_t] <= rdata;
    end
    sq       <= diff_mag * diff_mag;
    sq_first <= p1_first;
    sq_last  <= p1_last;
    sq_idx   <= p1_idx;
    if (sq_v) begin
      acc     <= acc_new;
      acc_idx <= sq_idx;
    end
  end

  assign ch_v[0]   = acc_done;
  assign ch_d[0]   = acc;
  assign ch_idx[0] = acc_idx;

  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
    nnsf_cell #(.DW(DW), .IW(AW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .clr    (clr_chain),
      .in_v   (ch_v[g]),
      .in_d   (ch_d[g]),
      .in_idx (ch_idx[g]),
      .out_v  (ch_v[g+1]),
      .out_d  (ch_d[g+1]),
      .out_idx(ch_idx[g+1]),
      .occ    (c_occ[g]),
      .idx    (c_idx[g])
    );
  end

  nnsf_div #(.SW(SW), .NW(KW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .divisor (filled),
    .done    (div_done),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= state == S_SUMW;
      m_tvalid  <= state == S_DONE || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            res_valid <= 1'b0;
            res_used  <= '0;
            res_full  <= cnt_eff == CNTW'(HISTORY_DEPTH);
            t         <= '0;
            j         <= '0;
            if (cnt_eff == CNTW'(HISTORY_DEPTH)) begin
              count <= cnt_eff;
              state <= S_DONE;
            end else begin
              count <= n;
              if (32'(n) < 32'(sp) || n <= CNTW'(m)) begin
                state <= S_DONE;
              end else begin
                newest <= newest_calc[AW-1:0];
                filled <= 32'(newest_calc) < 32'(k) ? KW'(newest_calc) : k;
                state  <= S_VEC;
              end
            end
          end
        end
        S_VEC: begin
          if (t == m - 1'b1) begin
            t     <= '0;
            state <= S_SCAN;
          end else begin
            t <= t + 1'b1;
          end
        end
        S_SCAN: begin
          if (last_issue) begin
            drain <= '0;
            state <= S_DRAIN;
          end else if (t == m - 1'b1) begin
            t <= '0;
            j <= j + 1'b1;
          end else begin
            t <= t + 1'b1;
          end
        end
        S_DRAIN: begin
          drain <= drain + 1'b1;
          if (drain == DRW'(MAX_NEIGHBORS + 4)) begin
            i     <= '0;
            sum   <= '0;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          i <= i + 1'b1;
          if (i == filled - 1'b1) begin
            state <= S_SUMW;
          end
        end
        S_SUMW: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res_value <= quotient[SAMPLE_W-1:0];
            res_valid <= 1'b1;
            res_used  <= USED_W'(filled);
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {3'b000, res_used, res_value};
            m_tuser  <= {res_full, res_valid};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (p1_v && p1_kind == K_SUM) begin
        sum <= sum + SW'($signed(rdata));
      end
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("forecast and full flag both set");

  a_used_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[20:16] == '0 && m_tdata[15:0] == '0))
    else $error("invalid result carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= HISTORY_DEPTH)
    else $error("sample count beyond depth");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (filled != '0 && filled <= k && c_occ[i[CW-1:0]]))
    else $error("neighbor read from empty cell");

endmodule
